/* rtl/cplp_pkg.sv */
// Shared types, constants and tables for the complex-pole two-pole lowpass.
`default_nettype none
package cplp_pkg;

   // default field widths
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int STATE_BITS_DEF  = 40;

   // coefficient format and register widths
   localparam int COEF_BITS = 32;
   localparam int CFG_BITS  = 15;
   localparam int FRAC_BITS = 30;

   // coefficient engine datapath widths
   localparam int ENG_BITS = 40;
   localparam int QUO_BITS = 67;

   // Q2.30 constants: pi/2 and sqrt(1/2)
   localparam logic [31:0] HALF_PI_Q   = 32'd1686629713;
   localparam logic [31:0] SQRT_HALF_Q = 32'd759250124;

   // register indexes
   typedef enum logic [0:0] {
      REG_CUTOFF    = 1'b0,
      REG_RESONANCE = 1'b1
   } reg_index_type;

   // pole and gain, Q2.30
   typedef struct packed {
      logic signed [COEF_BITS-1:0] zr;
      logic signed [COEF_BITS-1:0] zi;
      logic signed [COEF_BITS-1:0] gain;
   } coef_type;

   // coefficient engine sequencer
   typedef enum logic [3:0] {
      CS_IDLE,
      CS_TH,
      CS_X2,
      CS_HMUL,
      CS_HDIV,
      CS_SN,
      CS_W,
      CS_A,
      CS_B,
      CS_A2,
      CS_B2,
      CS_DEN,
      CS_C0,
      CS_C1,
      CS_C2
   } coef_state_type;

   // sample datapath sequencer
   typedef enum logic [2:0] {
      FS_IDLE,
      FS_MUL,
      FS_SUM1,
      FS_SUM2,
      FS_GAIN,
      FS_OUT
   } filt_state_type;

   // Horner denominators of the sine and cosine series, innermost term first
   function automatic logic [7:0] horner_den(input logic is_cos, input logic [2:0] idx);
      logic [7:0] d;
      d = 8'd1;
      if (is_cos) begin
         unique case (idx)
            3'd0: d = 8'd132;
            3'd1: d = 8'd90;
            3'd2: d = 8'd56;
            3'd3: d = 8'd30;
            3'd4: d = 8'd12;
            3'd5: d = 8'd2;
            default: d = 8'd1;
         endcase
      end else begin
         unique case (idx)
            3'd0: d = 8'd156;
            3'd1: d = 8'd110;
            3'd2: d = 8'd72;
            3'd3: d = 8'd42;
            3'd4: d = 8'd20;
            3'd5: d = 8'd6;
            default: d = 8'd1;
         endcase
      end
      return d;
   endfunction

endpackage
`default_nettype wire

/* rtl/complex_pole_lowpass_2_top.sv */
// Top level of the complex-pole two-pole resonant lowpass: register port, coefficient engine, datapath.
//
// Two-pole resonant lowpass built from two cascaded complex one-pole sections with conjugate
// poles. Write cutoff_fraction at byte address 0 and resonance at 4; each write, and the release
// of reset, starts a recomputation of the pole and gain in a serial engine (one multiplier bit or
// one quotient bit per cycle: 20 products and 16 quotients), during which req_tready is low. A
// sample goes through a pass of eight bit-serial multiplier lanes for both sections, two summing
// steps, a second pass for the gain, and the output load; a new sample is taken only once the
// previous one has been loaded into the result register. The result register lets the block take
// the next sample while the previous result still waits on the rsp side.
`default_nettype none
module complex_pole_lowpass_2_top #(
   parameter int SAMPLE_BITS = cplp_pkg::SAMPLE_BITS_DEF,
   parameter int STATE_BITS  = cplp_pkg::STATE_BITS_DEF,
   localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request stream
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [DATA_BITS-1:0] req_tdata,   // [SAMPLE_BITS-1:0] sample_in
   // result stream
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [DATA_BITS-1:0]      rsp_tdata,   // [SAMPLE_BITS-1:0] sample_out
   // register port
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import cplp_pkg::*;

   logic [CFG_BITS-1:0] cutoff_ff, cutoff_in, res_ff, res_in;
   logic                start_ff, start_in;
   logic                csr_wr;
   logic                coef_busy, eng_busy, filt_ready;
   reg_index_type       csr_idx;
   coef_type            coefs;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[2]);

   always_comb begin
      cutoff_in = cutoff_ff;
      res_in    = res_ff;
      start_in  = csr_wr;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_CUTOFF:    cutoff_in = csr_pwdata[CFG_BITS-1:0];
            REG_RESONANCE: res_in    = csr_pwdata[CFG_BITS-1:0];
            default:       cutoff_in = cutoff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CFG_BITS'(4096);
         res_ff    <= '0;
         start_ff  <= 1'b1;
      end else begin
         cutoff_ff <= cutoff_in;
         res_ff    <= res_in;
         start_ff  <= start_in;
      end
   end

   // register reads
   always_comb begin
      unique case (csr_idx)
         REG_CUTOFF:    csr_prdata = 32'(cutoff_ff);
         REG_RESONANCE: csr_prdata = 32'(res_ff);
         default:       csr_prdata = '0;
      endcase
   end

   cplp_coef u_coef (
      .clock(clock), .reset(reset), .start(start_ff), .cutoff(cutoff_ff),
      .resonance(res_ff), .busy(eng_busy), .coefs(coefs));

   // no sample transfer while coefficients are pending
   assign coef_busy = eng_busy || start_ff || csr_wr;

   cplp_filt #(.SAMPLE_BITS(SAMPLE_BITS), .STATE_BITS(STATE_BITS)) u_filt (
      .clock(clock), .reset(reset), .coef_busy(coef_busy), .coefs(coefs),
      .in_valid(req_tvalid), .in_ready(filt_ready),
      .in_sample($signed(req_tdata[SAMPLE_BITS-1:0])),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_sample(sample_out));

   assign req_tready = filt_ready;
   assign rsp_tdata  = DATA_BITS'($unsigned(sample_out));

`ifndef SYNTHESIS
   // a sample is never taken while the coefficients are being recomputed
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !eng_busy && !start_ff)
      else $error("sample transfer during coefficient update");

   // one sample at a time: the request side closes after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request side open right after a transfer");

   // a register write holds off samples until the engine has started
   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> !req_tready && start_ff)
      else $error("register write did not start a recomputation");
`endif
endmodule
`default_nettype wire

/* rtl/cplp_mul.sv */
// Bit-serial signed multiplier, one multiplier bit per cycle.
`default_nettype none
module cplp_mul #(
   parameter int AW = 40,
   parameter int BW = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [AW-1:0] a,
   input  wire logic signed [BW-1:0] b,
   output logic                      done,
   output logic signed [AW+BW-1:0]   prod
);
   localparam int CW = (BW > 1) ? $clog2(BW) : 1;

   logic [AW+BW-1:0] prod_ff, prod_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic signed [AW:0] upper;
   logic signed [AW:0] addend;
   logic signed [AW:0] sum;

   // shift-add step; the sign bit of b is weighted negative
   always_comb begin
      upper  = $signed({prod_ff[AW+BW-1], prod_ff[AW+BW-1:BW]});
      addend = prod_ff[0] ? $signed({a_ff[AW-1], a_ff}) : '0;
      sum    = (cnt_ff == CW'(BW-1)) ? upper - addend : upper + addend;
      prod_in = prod_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = {{AW{1'b0}}, b};
         a_in    = a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[BW-1:1]};
         cnt_in  = cnt_ff + CW'(1);
         if (cnt_ff == CW'(BW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      prod_ff <= prod_in;
      a_ff    <= a_in;
   end

   assign done = done_ff;
   assign prod = $signed(prod_ff);
endmodule
`default_nettype wire

/* rtl/cplp_div.sv */
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
`default_nettype none
module cplp_div #(
   parameter int NW = 67,
   parameter int DW = 40
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [NW-1:0] dividend,
   input  wire logic [DW-1:0]        divisor,
   output logic                      done,
   output logic signed [NW-1:0]      quot
);
   localparam int CW = $clog2(NW);

   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;

   // one restoring step per cycle on the magnitude
   always_comb begin
      shifted = {rem_ff, q_ff[NW-1]};
      diff    = shifted - {1'b0, d_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend[NW-1] ? $unsigned(-dividend) : $unsigned(dividend);
         rem_in  = '0;
         d_in    = divisor;
         neg_in  = dividend[NW-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule
`default_nettype wire

/* rtl/cplp_coef.sv */
// Coefficient engine: pole and gain from cutoff and resonance, on a serial multiplier and divider.
`default_nettype none
module cplp_coef (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [14:0]              cutoff,
   input  wire logic [14:0]              resonance,
   output logic                          busy,
   output cplp_pkg::coef_type            coefs
);
   import cplp_pkg::*;

   localparam int PW = 2 * ENG_BITS;
   localparam logic signed [ENG_BITS-1:0] ONE_E  = ENG_BITS'(64'd1 << FRAC_BITS);
   localparam logic signed [ENG_BITS-1:0] TWO_E  = ENG_BITS'(64'd1 << (FRAC_BITS + 1));
   localparam logic signed [PW-1:0]       HALF_P = PW'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [QUO_BITS-1:0] MAX_Q  = QUO_BITS'(64'h7fff_ffff);
   localparam logic signed [QUO_BITS-1:0] MIN_Q  = -MAX_Q - QUO_BITS'(1);

   coef_state_type state_ff, state_in;
   logic           go_ff, go_in;
   logic [2:0]     idx_ff, idx_in;
   logic           cos_ff, cos_in;
   logic signed [ENG_BITS-1:0] th_ff, th_in, x2_ff, x2_in, t_ff, t_in, p_ff, p_in;
   logic signed [ENG_BITS-1:0] sn_ff, sn_in, w_ff, w_in, a_ff, a_in, b_ff, b_in;
   logic signed [ENG_BITS-1:0] a2_ff, a2_in, b2_ff, b2_in, den_ff, den_in;
   coef_type coefs_ff, coefs_in;

   logic                        mul_start, mul_done;
   logic signed [ENG_BITS-1:0]  mul_a, mul_b;
   logic signed [PW-1:0]        mul_prod, mul_rsum;
   logic signed [ENG_BITS-1:0]  mul_trunc, mul_rnd, den_val, dr;
   logic                        div_start, div_done;
   logic signed [QUO_BITS-1:0]  div_n, div_q, numr;
   logic [ENG_BITS-1:0]         div_d;

   function automatic logic signed [COEF_BITS-1:0] clamp_q(
      input logic signed [QUO_BITS-1:0] v, input logic floor_zero);
      logic signed [QUO_BITS-1:0] lo;
      logic signed [COEF_BITS-1:0] r;
      lo = floor_zero ? '0 : MIN_Q;
      if (v > MAX_Q) r = MAX_Q[COEF_BITS-1:0];
      else if (v < lo) r = lo[COEF_BITS-1:0];
      else r = v[COEF_BITS-1:0];
      return r;
   endfunction

   cplp_mul #(.AW(ENG_BITS), .BW(ENG_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(mul_prod));

   cplp_div #(.NW(QUO_BITS), .DW(ENG_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_n),
      .divisor(div_d), .done(div_done), .quot(div_q));

   // product scalings: truncated and rounded half up
   assign mul_rsum  = mul_prod + HALF_P;
   assign mul_trunc = mul_prod[FRAC_BITS+ENG_BITS-1:FRAC_BITS];
   assign mul_rnd   = mul_rsum[FRAC_BITS+ENG_BITS-1:FRAC_BITS];
   assign dr        = TWO_E - a_ff;
   assign den_val   = mul_rnd + b2_ff;
   assign numr      = $signed(QUO_BITS'(1) << (FRAC_BITS + 2))
                      - QUO_BITS'(a2_ff) - QUO_BITS'(b2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
      end
      idx_ff   <= idx_in;
      cos_ff   <= cos_in;
      th_ff    <= th_in;
      x2_ff    <= x2_in;
      t_ff     <= t_in;
      p_ff     <= p_in;
      sn_ff    <= sn_in;
      w_ff     <= w_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      a2_ff    <= a2_in;
      b2_ff    <= b2_in;
      den_ff   <= den_in;
      coefs_ff <= coefs_in;
   end

   // sequencer: each step issues one operation and latches its result
   always_comb begin
      state_in  = state_ff;
      go_in     = 1'b0;
      idx_in    = idx_ff;
      cos_in    = cos_ff;
      th_in     = th_ff;
      x2_in     = x2_ff;
      t_in      = t_ff;
      p_in      = p_ff;
      sn_in     = sn_ff;
      w_in      = w_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      a2_in     = a2_ff;
      b2_in     = b2_ff;
      den_in    = den_ff;
      coefs_in  = coefs_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_n     = '0;
      div_d     = '0;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
         end
         CS_TH: begin
            mul_a = $signed({8'd0, HALF_PI_Q});
            mul_b = $signed({25'd0, cutoff});
            mul_start = go_ff;
            // a restart can meet the done pulse of the aborted product
            if (mul_done && !go_ff) begin
               th_in = mul_prod[ENG_BITS+15:16];
               state_in = CS_X2;
               go_in = 1'b1;
            end
         end
         CS_X2: begin
            mul_a = th_ff;
            mul_b = th_ff;
            mul_start = go_ff;
            if (mul_done) begin
               x2_in  = mul_trunc;
               t_in   = ONE_E;
               idx_in = '0;
               cos_in = 1'b0;
               state_in = CS_HMUL;
               go_in = 1'b1;
            end
         end
         CS_HMUL: begin
            mul_a = x2_ff;
            mul_b = t_ff;
            mul_start = go_ff;
            if (mul_done) begin
               p_in = mul_trunc;
               state_in = CS_HDIV;
               go_in = 1'b1;
            end
         end
         CS_HDIV: begin
            div_n = QUO_BITS'(p_ff);
            div_d = ENG_BITS'(horner_den(cos_ff, idx_ff));
            div_start = go_ff;
            if (div_done) begin
               t_in = ONE_E - div_q[ENG_BITS-1:0];
               go_in = 1'b1;
               if (idx_ff == 3'd5) begin
                  idx_in = '0;
                  state_in = cos_ff ? CS_W : CS_SN;
               end else begin
                  idx_in = idx_ff + 3'd1;
                  state_in = CS_HMUL;
               end
            end
         end
         CS_SN: begin
            mul_a = th_ff;
            mul_b = t_ff;
            mul_start = go_ff;
            if (mul_done) begin
               sn_in  = mul_trunc;
               t_in   = ONE_E;
               cos_in = 1'b1;
               idx_in = '0;
               state_in = CS_HMUL;
               go_in = 1'b1;
            end
         end
         CS_W: begin
            div_n = QUO_BITS'(sn_ff) <<< (FRAC_BITS + 1);
            div_d = (t_ff == '0) ? ENG_BITS'(1) : $unsigned(t_ff);
            div_start = go_ff;
            if (div_done) begin
               w_in = div_q[ENG_BITS-1:0];
               state_in = CS_A;
               go_in = 1'b1;
            end
         end
         CS_A: begin
            mul_a = $signed({10'd0, resonance, 15'd0}) - $signed({8'd0, SQRT_HALF_Q});
            mul_b = w_ff;
            mul_start = go_ff;
            if (mul_done) begin
               a_in = mul_rnd;
               state_in = CS_B;
               go_in = 1'b1;
            end
         end
         CS_B: begin
            mul_a = $signed({8'd0, SQRT_HALF_Q});
            mul_b = w_ff;
            mul_start = go_ff;
            if (mul_done) begin
               b_in = mul_rnd;
               state_in = CS_A2;
               go_in = 1'b1;
            end
         end
         CS_A2: begin
            mul_a = a_ff;
            mul_b = a_ff;
            mul_start = go_ff;
            if (mul_done) begin
               a2_in = mul_rnd;
               state_in = CS_B2;
               go_in = 1'b1;
            end
         end
         CS_B2: begin
            mul_a = b_ff;
            mul_b = b_ff;
            mul_start = go_ff;
            if (mul_done) begin
               b2_in = mul_rnd;
               state_in = CS_DEN;
               go_in = 1'b1;
            end
         end
         CS_DEN: begin
            mul_a = dr;
            mul_b = dr;
            mul_start = go_ff;
            if (mul_done) begin
               den_in = (den_val <= 0) ? ENG_BITS'(1) : den_val;
               state_in = CS_C0;
               go_in = 1'b1;
            end
         end
         CS_C0: begin
            div_n = numr <<< FRAC_BITS;
            div_d = $unsigned(den_ff);
            div_start = go_ff;
            if (div_done) begin
               coefs_in.zr = clamp_q(div_q, 1'b0);
               state_in = CS_C1;
               go_in = 1'b1;
            end
         end
         CS_C1: begin
            div_n = QUO_BITS'(b_ff) <<< (FRAC_BITS + 2);
            div_d = $unsigned(den_ff);
            div_start = go_ff;
            if (div_done) begin
               coefs_in.zi = clamp_q(div_q, 1'b0);
               state_in = CS_C2;
               go_in = 1'b1;
            end
         end
         CS_C2: begin
            div_n = (QUO_BITS'(a2_ff) + QUO_BITS'(b2_ff)) <<< FRAC_BITS;
            div_d = $unsigned(den_ff);
            div_start = go_ff;
            if (div_done) begin
               coefs_in.gain = clamp_q(div_q, 1'b1);
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
      // a new request restarts the whole computation
      if (start) begin
         state_in = CS_TH;
         go_in = 1'b1;
      end
   end

   assign busy  = (state_ff != CS_IDLE);
   assign coefs = coefs_ff;
endmodule
`default_nettype wire

/* rtl/cplp_filt.sv */
// Sample datapath: two cascaded complex one-pole sections on eight bit-serial multiplier lanes.
`default_nettype none
module cplp_filt #(
   parameter int SAMPLE_BITS = cplp_pkg::SAMPLE_BITS_DEF,
   parameter int STATE_BITS  = cplp_pkg::STATE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          coef_busy,
   input  wire cplp_pkg::coef_type            coefs,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [SAMPLE_BITS-1:0]      out_sample
);
   import cplp_pkg::*;

   localparam int LANES = 8;
   localparam int AW = STATE_BITS + 1;
   localparam int PW = AW + COEF_BITS;
   localparam int RW = PW - FRAC_BITS;
   localparam int SW = STATE_BITS + 4;
   localparam logic signed [PW-1:0] HALF_P = PW'(64'd1 << (FRAC_BITS - 1));

   filt_state_type state_ff, state_in;
   logic go_ff, go_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in, out_ff, out_in;
   logic out_valid_ff, out_valid_in;
   logic signed [STATE_BITS-1:0] s1r_ff, s1r_in, s1i_ff, s1i_in;
   logic signed [STATE_BITS-1:0] s2r_ff, s2r_in, s2i_ff, s2i_in;
   logic signed [STATE_BITS:0]   y1r_ff, y1r_in, y1i_ff, y1i_in, y2r_ff, y2r_in;
   logic signed [STATE_BITS-1:0] t1r, t1i, t2r, t2i;

   logic signed [AW-1:0]        lane_a [LANES];
   logic signed [COEF_BITS-1:0] lane_b [LANES];
   logic signed [PW-1:0]        lane_p [LANES];
   logic signed [RW-1:0]        lane_r [LANES];
   logic [LANES-1:0]            lane_done;
   logic                        lane_start;

   function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [SW-1:0] v);
      logic signed [STATE_BITS-1:0] r;
      if (v[SW-1:STATE_BITS-1] == '0 || v[SW-1:STATE_BITS-1] == '1)
         r = v[STATE_BITS-1:0];
      else
         r = {v[SW-1], {(STATE_BITS-1){~v[SW-1]}}};
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [RW-1:0] v);
      logic signed [SAMPLE_BITS-1:0] r;
      if (v[RW-1:SAMPLE_BITS-1] == '0 || v[RW-1:SAMPLE_BITS-1] == '1)
         r = v[SAMPLE_BITS-1:0];
      else
         r = {v[RW-1], {(SAMPLE_BITS-1){~v[RW-1]}}};
      return r;
   endfunction

   // lane operands: section one, section two, then the gain on lane 0
   always_comb begin
      lane_a[0] = (state_ff == FS_GAIN) ? y2r_ff : AW'(s1r_ff);
      lane_b[0] = (state_ff == FS_GAIN) ? coefs.gain : coefs.zr;
      lane_a[1] = AW'(s1i_ff);  lane_b[1] = coefs.zi;
      lane_a[2] = AW'(s1i_ff);  lane_b[2] = coefs.zr;
      lane_a[3] = AW'(s1r_ff);  lane_b[3] = coefs.zi;
      lane_a[4] = AW'(s2r_ff);  lane_b[4] = coefs.zr;
      lane_a[5] = AW'(s2i_ff);  lane_b[5] = coefs.zi;
      lane_a[6] = AW'(s2i_ff);  lane_b[6] = coefs.zr;
      lane_a[7] = AW'(s2r_ff);  lane_b[7] = coefs.zi;
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic signed [PW-1:0] rsum;
      cplp_mul #(.AW(AW), .BW(COEF_BITS)) u_mul (
         .clock(clock), .reset(reset), .start(lane_start), .a(lane_a[k]), .b(lane_b[k]),
         .done(lane_done[k]), .prod(lane_p[k]));
      // rounded half up
      assign rsum      = lane_p[k] + HALF_P;
      assign lane_r[k] = rsum[PW-1:FRAC_BITS];
   end

   // section updates
   assign t1r = sat_state(SW'(x_ff) + SW'(lane_r[0]) - SW'(lane_r[1]));
   assign t1i = sat_state(SW'(lane_r[2]) + SW'(lane_r[3]));
   assign t2r = sat_state(SW'(y1r_ff) + SW'(lane_r[4]) + SW'(lane_r[5]));
   assign t2i = sat_state(SW'(y1i_ff) + SW'(lane_r[6]) - SW'(lane_r[7]));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_IDLE;
         go_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         s1r_ff       <= '0;
         s1i_ff       <= '0;
         s2r_ff       <= '0;
         s2i_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         out_valid_ff <= out_valid_in;
         s1r_ff       <= s1r_in;
         s1i_ff       <= s1i_in;
         s2r_ff       <= s2r_in;
         s2i_ff       <= s2i_in;
      end
      x_ff   <= x_in;
      out_ff <= out_in;
      y1r_ff <= y1r_in;
      y1i_ff <= y1i_in;
      y2r_ff <= y2r_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      x_in         = x_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      s1r_in       = s1r_ff;
      s1i_in       = s1i_ff;
      s2r_in       = s2r_ff;
      s2i_in       = s2i_ff;
      y1r_in       = y1r_ff;
      y1i_in       = y1i_ff;
      y2r_in       = y2r_ff;
      lane_start   = 1'b0;
      in_ready     = 1'b0;
      if (out_valid_ff && out_ready) out_valid_in = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            in_ready = !coef_busy;
            if (in_valid && !coef_busy) begin
               x_in = in_sample;
               go_in = 1'b1;
               state_in = FS_MUL;
            end
         end
         FS_MUL: begin
            lane_start = go_ff;
            if (&lane_done) state_in = FS_SUM1;
         end
         FS_SUM1: begin
            s1r_in = t1r;
            s1i_in = t1i;
            y1r_in = (STATE_BITS+1)'(t1r) + (STATE_BITS+1)'(s1r_ff);
            y1i_in = (STATE_BITS+1)'(t1i) + (STATE_BITS+1)'(s1i_ff);
            state_in = FS_SUM2;
         end
         FS_SUM2: begin
            s2r_in = t2r;
            s2i_in = t2i;
            y2r_in = (STATE_BITS+1)'(t2r) + (STATE_BITS+1)'(s2r_ff);
            go_in = 1'b1;
            state_in = FS_GAIN;
         end
         FS_GAIN: begin
            lane_start = go_ff;
            if (lane_done[0]) state_in = FS_OUT;
         end
         FS_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_in = sat_out(lane_r[0]);
               out_valid_in = 1'b1;
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = out_ff;
endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the complex-pole two-pole resonant lowpass.
`default_nettype none

// Bit-accurate filter predictor with a queue of expected output samples
class lowpass_scoreboard;
   localparam longint ONE_Q     = 64'sd1 <<< 30;
   localparam longint SQRT_HALF = 64'sd759250124;

   int unsigned sin_den[6] = '{156, 110, 72, 42, 20, 6};
   int unsigned cos_den[6] = '{132, 90, 56, 30, 12, 2};

   int unsigned cutoff, resonance;
   longint      s1r, s1i, s2r, s2i;
   longint      zr, zi, gain;
   logic [23:0] expected_out[$];
   int          errors, checked, noted;

   function new();
      cutoff    = 4096;
      resonance = 0;
      s1r = 0; s1i = 0; s2r = 0; s2i = 0;
      errors = 0; checked = 0; noted = 0;
      recompute();
   endfunction

   function longint sat(longint v, int bits);
      longint hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   // product rounded half up at 2^30, split to stay within 64 bits
   function longint mulq(longint m, longint c);
      longint mh, ml;
      mh = m >>> 30;
      ml = m - (mh <<< 30);
      return mh * c + ((ml * c + (64'sd1 <<< 29)) >>> 30);
   endfunction

   function logic [63:0] horner(logic [63:0] x2, bit is_cos);
      logic [63:0] t;
      t = 64'd1 << 30;
      for (int i = 0; i < 6; i++)
         t = (64'd1 << 30) - ((x2 * t) >> 30) / (is_cos ? cos_den[i] : sin_den[i]);
      return t;
   endfunction

   function longint clamp32(longint v, longint lo);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < lo) return lo;
      return v;
   endfunction

   // pole and gain from cutoff and resonance
   function void recompute();
      logic [63:0] th, x2, sn, cs;
      longint w, a, b, a2, b2, dr, den, numr;
      th = (64'(cutoff) * 64'(cplp_pkg::HALF_PI_Q)) >> 16;
      x2 = (th * th) >> 30;
      sn = (th * horner(x2, 1'b0)) >> 30;
      cs = horner(x2, 1'b1);
      if (cs == 0) cs = 1;
      w    = $signed((sn << 31) / cs);
      a    = mulq(longint'(resonance) * 32768 - SQRT_HALF, w);
      b    = mulq(SQRT_HALF, w);
      a2   = mulq(a, a);
      b2   = mulq(b, b);
      dr   = 2 * ONE_Q - a;
      den  = mulq(dr, dr) + b2;
      if (den <= 0) den = 1;
      numr = 4 * ONE_Q - a2 - b2;
      zr   = clamp32((numr * ONE_Q) / den, -64'sd2147483648);
      zi   = clamp32((b * 4 * ONE_Q) / den, -64'sd2147483648);
      gain = clamp32(((a2 + b2) * ONE_Q) / den, 0);
   endfunction

   function void write_reg(cplp_pkg::reg_index_type idx, logic [31:0] value);
      if (idx == cplp_pkg::REG_CUTOFF) cutoff = value[14:0];
      else resonance = value[14:0];
      recompute();
   endfunction

   // accepted input sample: advance both sections, queue the output
   function void note_sample(logic signed [23:0] sample);
      longint x, tr, ti, yr, yi, t2r, t2i, y2r;
      x   = longint'(sample);
      tr  = sat(x + mulq(s1r, zr) - mulq(s1i, zi), 40);
      ti  = sat(mulq(s1i, zr) + mulq(s1r, zi), 40);
      yr  = tr + s1r;
      yi  = ti + s1i;
      s1r = tr;
      s1i = ti;
      t2r = sat(yr + mulq(s2r, zr) + mulq(s2i, zi), 40);
      t2i = sat(yi + mulq(s2i, zr) - mulq(s2r, zi), 40);
      y2r = t2r + s2r;
      s2r = t2r;
      s2i = t2i;
      expected_out.push_back(24'(sat(mulq(y2r, gain), 24)));
      noted++;
   endfunction

   function void check_sample(logic [23:0] got);
      logic [23:0] want;
      checked++;
      if (expected_out.size() == 0) begin
         $error("sample_out: result with no sample outstanding, actual %0d", $signed(got));
         errors++;
         return;
      end
      want = expected_out.pop_front();
      if (want !== got) begin
         $error("sample_out mismatch: expected %0d actual %0d", $signed(want), $signed(got));
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cplp_pkg::*;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [23:0] req_tdata;   // [23:0] sample_in
   logic        rsp_tvalid, rsp_tready;
   logic [23:0] rsp_tdata;   // [23:0] sample_out
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   lowpass_scoreboard sb = new();
   bit quiet;
   int reg_writes;

   complex_pole_lowpass_2_top uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result checker
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_sample(rsp_tdata);

   // receiver: random stall bursts, one long hold-off to back the block up
   initial begin
      int stall;
      bit pressed;
      stall = 0;
      pressed = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressed && sb.checked >= 150) begin
            pressed = 1;
            stall = 600;
         end else if (stall == 0 && !quiet && $urandom_range(0, 7) == 0)
            stall = $urandom_range(1, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else
            rsp_tready <= 1'b1;
      end
   end

   // one sample transfer, with an optional idle burst ahead of it
   task automatic send_sample(logic [23:0] sample);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(sample);
   endtask

   // register write, only once the filter has drained
   task automatic write_reg(reg_index_type idx, logic [14:0] value);
      logic [31:0] word;
      word = {$urandom() & 32'hFFFF_8000} | 32'(value);
      @(negedge clock) req_tvalid <= 1'b0;
      while (sb.expected_out.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {idx, 2'b00};
      csr_pwdata <= word;
      @(negedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, word);
      reg_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [23:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 24'h7F_FFFF;
         1: return 24'h80_0000;
         2: return 24'($signed($urandom_range(0, 2000)) - 1000);
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic directed_burst();
      send_sample(24'h7F_FFFF);
      send_sample(24'h80_0000);
      send_sample(24'h00_0000);
      send_sample(24'h00_0001);
      send_sample(24'hFF_FFFF);
   endtask

   initial begin
      logic [14:0] cut, res;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      quiet       = 0;
      reg_writes  = 0;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: reset setting, zero cutoff, resonance on and past the axis, top cutoff
      directed_burst();
      write_reg(REG_CUTOFF, 15'd0);
      directed_burst();
      write_reg(REG_CUTOFF, 15'd2000);
      write_reg(REG_RESONANCE, 15'd23170);
      directed_burst();
      write_reg(REG_RESONANCE, 15'd32767);
      directed_burst();
      write_reg(REG_CUTOFF, 15'd32767);
      write_reg(REG_RESONANCE, 15'd0);
      directed_burst();

      // random phases over a spread of settings
      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 4))
            0: cut = 15'd0;
            1: cut = 15'd1;
            2: cut = 15'd32767;
            3: cut = 15'($urandom_range(100, 8000));
            default: cut = 15'($urandom());
         endcase
         case ($urandom_range(0, 3))
            0: res = 15'd0;
            1: res = 15'd23170;
            2: res = 15'($urandom_range(23171, 32767));
            default: res = 15'($urandom_range(0, 23170));
         endcase
         write_reg(REG_CUTOFF, cut);
         write_reg(REG_RESONANCE, res);
         for (int i = 0; i < 94; i++) begin
            if (ph == 7 && i > 20) quiet = 1;
            send_sample(random_sample());
         end
      end
      @(negedge clock) req_tvalid <= 1'b0;

      while (sb.expected_out.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("Run covered %0d samples and %0d register writes,", sb.noted, reg_writes);
      $display("zero and top cutoff, resonance on and past the axis, saturation.");
      if (sb.errors == 0 && sb.expected_out.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
